// ===== src/smed_pkg.sv =====
// Shared constants, types and helpers for the sliding window median block.
package smed_pkg;

   // Window storage depth and derived widths
   localparam int MAX_WINDOW = 64;
   localparam int IDX_W      = $clog2(MAX_WINDOW);
   localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
   localparam int SMP_W      = 32;
   localparam int RES_W      = SMP_W + 1;
   localparam int WSIZE_W    = 7;

   localparam logic [WSIZE_W-1:0] WSIZE_RESET = WSIZE_W'(3);
   localparam logic [IDX_W-1:0]   AGE_OLDEST  = IDX_W'(MAX_WINDOW - 1);

   // Per-cycle command broadcast to every cell of the chain
   typedef struct packed {
      logic                    ins;      // insert a new sample (and maybe drop the oldest)
      logic                    clr;      // start of sequence: chain restarts with the sample
      logic                    rot;      // rotate the chain one cell toward the head
      logic                    del_en;   // chain is full, the oldest entry leaves
      logic [CNT_W-1:0]        fill;     // entries held before this insert
      logic signed [SMP_W-1:0] smp;      // incoming sample
      logic signed [SMP_W-1:0] oldest;   // value of the entry that leaves
   } smed_ctl_type;

   // What one cell shows its neighbors and the controller
   typedef struct packed {
      logic                    vld;
      logic [IDX_W-1:0]        age;
      logic signed [SMP_W-1:0] val;
      logic                    aa;       // sits at or above the new sample
      logic                    pp;       // sits above the leaving entry
      logic                    dd;       // is the leaving entry
   } smed_cell_type;

   localparam smed_cell_type CELL_NONE = '0;

   // Clamp the register value to 1..MAX_WINDOW
   function automatic logic [CNT_W-1:0] eff_window(input logic [WSIZE_W-1:0] wsize);
      int w;
      w = int'(wsize);
      if (w < 1) begin
         w = 1;
      end
      if (w > MAX_WINDOW) begin
         w = MAX_WINDOW;
      end
      return CNT_W'(w);
   endfunction

endpackage

// ===== src/smed_req_if.sv =====
// Input channel: one sample per transfer.
interface smed_req_if import smed_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [SMP_W-1:0] sample;
   logic                    first_of_sequence;

   modport source (output valid, sample, first_of_sequence, input ready);
   modport sink   (input valid, sample, first_of_sequence, output ready);
endinterface

// ===== src/smed_rsp_if.sv =====
// Result channel: one window median per transfer.
interface smed_rsp_if import smed_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [RES_W-1:0] median_half_units;

   modport source (output valid, median_half_units, input ready);
   modport sink   (input valid, median_half_units, output ready);
endinterface

// ===== src/sliding_window_median.sv =====
// Running median filter top level: sorted cell chain plus scan controller.
//
// The block keeps the newest MAX_WINDOW (64) samples in a chain of cells sorted
// by value, each tagged with its age. A sample transfer inserts the sample and,
// when the chain is full, drops the oldest entry together with the insert; the
// chain then rotates once around past the head cell, where the entries younger
// than the window size are counted in ascending order and the two middle ones
// are picked up. A scan that yields a result then loads the output register in
// the emit step; no new sample is taken until the scan and that step are done.
// A result appears once the number of samples since the last start flag reaches
// the window size, and is twice the median (the sum of the two middle values
// for an even window). The window size register takes 0 as 1 and values above
// 64 as 64; write it only while no sample is in flight. A waiting result does
// not block the next sample, but if it is still untaken when that sample's scan
// ends, the new result waits in the emit step and the input stays closed until
// the output frees.
module sliding_window_median import smed_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   smed_req_if.sink           req_ch,
   smed_rsp_if.source         rsp_ch,
   input  logic               csr_we,
   input  logic [WSIZE_W-1:0] csr_wdata
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [WSIZE_W-1:0]      wsize_ff;
   logic [1:0]              state_ff, state_in;
   logic [CNT_W-1:0]        fill_ff, fill_in;
   logic [CNT_W-1:0]        wk_ff, wk_in;
   logic                    need_ff, need_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [IDX_W-1:0]        step_ff, step_in;
   logic signed [SMP_W-1:0] lo_ff, lo_in;
   logic signed [SMP_W-1:0] hi_ff, hi_in;
   logic signed [SMP_W-1:0] oldest_ff, oldest_in;
   logic                    rsp_vld_ff, rsp_vld_in;
   logic signed [RES_W-1:0] rsp_data_ff, rsp_data_in;

   logic                    req_fire;
   logic                    full;
   logic [CNT_W-1:0]        fill_next;
   logic [CNT_W-1:0]        k_lo, k_hi;
   logic                    win_hit;
   smed_ctl_type            ctl;
   smed_cell_type           head;
   smed_cell_type           cell_view [MAX_WINDOW];

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign full         = (fill_ff == CNT_W'(MAX_WINDOW));

   assign rsp_ch.valid             = rsp_vld_ff;
   assign rsp_ch.median_half_units = rsp_data_ff;

   // Window size register
   always_ff @(posedge clock) begin
      if (reset) begin
         wsize_ff <= WSIZE_RESET;
      end else if (csr_we) begin
         wsize_ff <= csr_wdata;
      end
   end

   // Command to the chain
   always_comb begin
      ctl        = '0;
      ctl.ins    = req_fire;
      ctl.clr    = req_fire && req_ch.first_of_sequence;
      ctl.rot    = (state_ff == ST_SCAN);
      ctl.del_en = req_fire && !req_ch.first_of_sequence && full;
      ctl.fill   = fill_ff;
      ctl.smp    = req_ch.sample;
      ctl.oldest = oldest_ff;
   end

   // Cell chain: each cell sees its neighbors, rotation wraps the head around to the tail
   for (genvar gi = 0; gi < MAX_WINDOW; gi++) begin : g_cell
      smed_cell_type left_v, right_v;
      if (gi == 0) begin : g_left_edge
         assign left_v = CELL_NONE;
      end else begin : g_left
         assign left_v = cell_view[gi-1];
      end
      if (gi == MAX_WINDOW - 1) begin : g_right_edge
         assign right_v = CELL_NONE;
      end else begin : g_right
         assign right_v = cell_view[gi+1];
      end
      smed_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_idx (IDX_W'(gi)),
         .ctl      (ctl),
         .left_nb  (left_v),
         .right_nb (right_v),
         .rot_src  (cell_view[(gi + 1) % MAX_WINDOW]),
         .view     (cell_view[gi])
      );
   end

   // Head of the chain during the scan
   assign head    = cell_view[0];
   assign win_hit = head.vld && (CNT_W'(head.age) < wk_ff);
   assign k_lo    = (wk_ff - CNT_W'(1)) >> 1;
   assign k_hi    = wk_ff >> 1;

   assign fill_next = req_ch.first_of_sequence ? CNT_W'(1) :
                      (full ? fill_ff : fill_ff + CNT_W'(1));

   // Sequencer: insert, rotate once around, then load the output register when a result is due
   always_comb begin
      state_in    = state_ff;
      fill_in     = fill_ff;
      wk_in       = wk_ff;
      need_in     = need_ff;
      cnt_in      = cnt_ff;
      step_in     = step_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      oldest_in   = oldest_ff;
      rsp_vld_in  = rsp_vld_ff;
      rsp_data_in = rsp_data_ff;

      if (rsp_vld_ff && rsp_ch.ready) begin
         rsp_vld_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               fill_in  = fill_next;
               wk_in    = eff_window(wsize_ff);
               need_in  = (fill_next >= eff_window(wsize_ff));
               cnt_in   = '0;
               step_in  = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (win_hit) begin
               if (cnt_ff == k_lo) begin
                  lo_in = head.val;
               end
               if (cnt_ff == k_hi) begin
                  hi_in = head.val;
               end
               cnt_in = cnt_ff + CNT_W'(1);
            end
            // next entry to leave the window ring
            if (head.vld && head.age == AGE_OLDEST) begin
               oldest_in = head.val;
            end
            step_in = step_ff + IDX_W'(1);
            if (step_ff == IDX_W'(MAX_WINDOW - 1)) begin
               step_in  = '0;
               state_in = need_ff ? ST_EMIT : ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (!rsp_vld_ff || rsp_ch.ready) begin
               rsp_vld_in  = 1'b1;
               rsp_data_in = RES_W'(lo_ff) + RES_W'(hi_ff);
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         fill_ff    <= '0;
         step_ff    <= '0;
         cnt_ff     <= '0;
         need_ff    <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         fill_ff    <= fill_in;
         step_ff    <= step_in;
         cnt_ff     <= cnt_in;
         need_ff    <= need_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      wk_ff       <= wk_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      oldest_ff   <= oldest_in;
      rsp_data_ff <= rsp_data_in;
   end

   // A full window is seen in every scan that yields a result
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (cnt_ff == wk_ff))
      else $error("in-window count differs from window size at emit");

   // The result register only fills from the emit step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_vld_ff) |-> $past(state_ff == ST_EMIT))
      else $error("result appeared outside the emit step");

   // The sample count never passes the chain depth
   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(MAX_WINDOW))
      else $error("fill count beyond chain depth");

   // A transfer starts a full rotation of the chain
   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_SCAN) && (step_ff == '0))
      else $error("scan did not start after a sample transfer");

endmodule

// ===== src/smed_cell.sv =====
// One cell of the sorted chain: holds a sample, its age and a valid bit.
module smed_cell import smed_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic [IDX_W-1:0]   cell_idx,
   input  smed_ctl_type       ctl,
   input  smed_cell_type      left_nb,
   input  smed_cell_type      right_nb,
   input  smed_cell_type      rot_src,
   output smed_cell_type      view
);

   logic                    vld_ff, vld_in;
   logic [IDX_W-1:0]        age_ff, age_in;
   logic signed [SMP_W-1:0] val_ff, val_in;
   logic                    aa, pp, dd;
   logic                    grow;
   logic                    keep_self, from_right, from_left;

   // Position flags against the broadcast sample and the leaving entry
   assign aa = vld_ff && (val_ff >= ctl.smp);
   assign pp = ctl.del_en && vld_ff && (val_ff > ctl.oldest);
   assign dd = ctl.del_en && vld_ff && (age_ff == AGE_OLDEST);

   assign view = '{vld: vld_ff, age: age_ff, val: val_ff, aa: aa, pp: pp, dd: dd};

   // This cell becomes occupied when the chain grows by one
   assign grow = (ctl.fill == CNT_W'(cell_idx));

   // Source of the new content: an entry stays, moves down, moves up, or the sample lands
   assign keep_self  = vld_ff && !dd && (aa == pp);
   assign from_right = right_nb.vld && !right_nb.dd && right_nb.pp && !right_nb.aa;
   assign from_left  = left_nb.vld && !left_nb.dd && !left_nb.pp && left_nb.aa;

   always_comb begin
      vld_in = vld_ff;
      age_in = age_ff;
      val_in = val_ff;
      priority if (ctl.clr) begin
         vld_in = (cell_idx == '0);
         age_in = '0;
         val_in = ctl.smp;
      end else if (ctl.ins) begin
         priority if (keep_self) begin
            vld_in = 1'b1;
            age_in = age_ff + IDX_W'(1);
            val_in = val_ff;
         end else if (from_right) begin
            vld_in = 1'b1;
            age_in = right_nb.age + IDX_W'(1);
            val_in = right_nb.val;
         end else if (from_left) begin
            vld_in = 1'b1;
            age_in = left_nb.age + IDX_W'(1);
            val_in = left_nb.val;
         end else if (vld_ff || grow) begin
            vld_in = 1'b1;
            age_in = '0;
            val_in = ctl.smp;
         end else begin
            vld_in = 1'b0;
         end
      end else if (ctl.rot) begin
         vld_in = rot_src.vld;
         age_in = rot_src.age;
         val_in = rot_src.val;
      end else begin
         // no command: hold
         vld_in = vld_ff;
      end
   end

   // Valid bit is control state; value and age are payload
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      age_ff <= age_in;
      val_ff <= val_in;
   end

endmodule
